### hdl/sla_pkg.sv
// shared types and constants for the status led animator
`default_nettype none
package sla_pkg;

  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned CONN_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LOW  = 1'd1;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 16'd32;
  localparam logic [LEVEL_W-1:0] FLASH_LOW_RST  = 8'd32;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 8'd255;

  // connection state codes
  localparam logic [CONN_W-1:0] CONN_NO_WAN  = 2'd0;
  localparam logic [CONN_W-1:0] CONN_NO_INET = 2'd1;
  localparam logic [CONN_W-1:0] CONN_HEALTHY = 2'd2;

  typedef enum logic [1:0] {
    MODE_SOLID   = 2'd0,
    MODE_BREATHE = 2'd1,
    MODE_PULSE   = 2'd2,
    MODE_FLASH   = 2'd3
  } anim_mode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  localparam rgb_t RGB_BLACK  = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
  localparam rgb_t RGB_RED    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
  localparam rgb_t RGB_ORANGE = '{red: 8'd255, green: 8'd104, blue: 8'd3};
  localparam rgb_t RGB_GREEN  = '{red: 8'd18,  green: 8'd255, blue: 8'd144};

  // animation state after one tick, handed from the state stage to the wave stage
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    anim_mode_t         mode;
    rgb_t               colour;
  } led_state_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [LEVEL_W-1:0] flash_low;
  } cfg_regs_t;

endpackage
`default_nettype wire

### hdl/sla_cfg.sv
// configuration registers: phase step and flash low level
`default_nettype none
module sla_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sla_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output sla_pkg::cfg_regs_t                 regs
);

  sla_pkg::cfg_regs_t regs_r;
  sla_pkg::cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        sla_pkg::CFG_PHASE_STEP: regs_nxt.phase_step = cfg_wdata;
        sla_pkg::CFG_FLASH_LOW:  regs_nxt.flash_low  = cfg_wdata[sla_pkg::LEVEL_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.phase_step <= sla_pkg::PHASE_STEP_RST;
      regs_r.flash_low  <= sla_pkg::FLASH_LOW_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule
`default_nettype wire

### hdl/sla_state.sv
// tick stage: phase advance, mode and colour selection
`default_nettype none
module sla_state (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_take,
  input  wire logic [sla_pkg::CONN_W-1:0]  conn_state,
  input  wire logic [sla_pkg::PHASE_W-1:0] phase_step,
  input  wire logic                        st_take,
  output logic                             st_valid,
  output sla_pkg::led_state_t              st
);

  sla_pkg::led_state_t st_r;
  sla_pkg::led_state_t st_nxt;
  logic                st_valid_r;
  logic                st_valid_nxt;

  always_comb begin
    st_nxt = st_r;
    if (in_take) begin
      st_nxt.phase = st_r.phase + phase_step;
      case (conn_state)
        sla_pkg::CONN_NO_WAN: begin
          st_nxt.mode   = sla_pkg::MODE_FLASH;
          st_nxt.colour = sla_pkg::RGB_RED;
        end
        sla_pkg::CONN_NO_INET: begin
          st_nxt.mode   = sla_pkg::MODE_PULSE;
          st_nxt.colour = sla_pkg::RGB_ORANGE;
        end
        sla_pkg::CONN_HEALTHY: begin
          st_nxt.mode   = sla_pkg::MODE_BREATHE;
          st_nxt.colour = sla_pkg::RGB_GREEN;
        end
        // other states keep mode and colour
        default: begin
          st_nxt.mode   = st_r.mode;
          st_nxt.colour = st_r.colour;
        end
      endcase
    end
  end

  always_comb begin
    if (in_take) begin
      st_valid_nxt = 1'b1;
    end else if (st_take) begin
      st_valid_nxt = 1'b0;
    end else begin
      st_valid_nxt = st_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= '0;
      st_r.mode   <= sla_pkg::MODE_SOLID;
      st_r.colour <= sla_pkg::RGB_BLACK;
      st_valid_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      st_valid_r <= st_valid_nxt;
    end
  end

  assign st       = st_r;
  assign st_valid = st_valid_r;

endmodule
`default_nettype wire

### hdl/sla_wave.sv
// wave stage: brightness from mode and phase, result register
`default_nettype none
module sla_wave (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        st_valid,
  input  wire sla_pkg::led_state_t         st,
  input  wire logic [sla_pkg::LEVEL_W-1:0] flash_low,
  input  wire logic                        out_stall,
  output logic                             st_take,
  output logic                             out_valid,
  output sla_pkg::rgb_t                    out_colour,
  output logic [sla_pkg::LEVEL_W-1:0]      out_level
);

  logic                               low_half;
  logic [sla_pkg::PHASE_W-1:0]        sq_in;
  logic [2*sla_pkg::PHASE_W-1:0]      sq;
  logic [sla_pkg::LEVEL_W-1:0]        level;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  sla_pkg::rgb_t                      colour_r;
  logic [sla_pkg::LEVEL_W-1:0]        level_r;

  assign low_half = !st.phase[sla_pkg::PHASE_W-1];

  // breathe's upper half squares the distance to full scale, 65535 - p
  assign sq_in = (st.mode == sla_pkg::MODE_BREATHE && !low_half) ? ~st.phase : st.phase;
  assign sq    = sq_in * sq_in;

  always_comb begin
    case (st.mode)
      sla_pkg::MODE_BREATHE: begin
        // (sq >> 15) >> 8, mirrored about full scale in the upper half
        level = low_half ? sq[30:23] : ~sq[30:23];
      end
      sla_pkg::MODE_PULSE: level = ~sq[31:24];
      sla_pkg::MODE_FLASH: level = low_half ? sla_pkg::LEVEL_FULL : flash_low;
      default:             level = sla_pkg::LEVEL_FULL;
    endcase
  end

  assign st_take = st_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (st_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_take) begin
      colour_r <= st.colour;
      level_r  <= level;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_colour = colour_r;
  assign out_level  = level_r;

endmodule
`default_nettype wire

### hdl/status_led_animator.sv
// top level of the status led animator
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     in_connection_state[1:0]
//   out      output     out_valid / out_stall   out_red, out_green, out_blue, out_brightness
//   cfg      input      cfg_wr_en               cfg_index[0], cfg_wdata[15:0]
//
// one tick per cycle while in_stall is low; a tick passes the tick and wave stage registers
// the tick stage updates phase, mode and colour, the wave stage squares the phase
// reset (rst_n low, synchronous) gives solid black, phase zero, step 32, flash low 32
// in_stall rises only when both stages hold a beat and out_stall is high
`default_nettype none
module status_led_animator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [sla_pkg::CONN_W-1:0]     in_connection_state,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [sla_pkg::CHAN_W-1:0]          out_red,
  output logic [sla_pkg::CHAN_W-1:0]          out_green,
  output logic [sla_pkg::CHAN_W-1:0]          out_blue,
  output logic [sla_pkg::LEVEL_W-1:0]         out_brightness,
  input  wire logic                           cfg_wr_en,
  input  wire logic [sla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sla_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sla_pkg::cfg_regs_t  regs;
  sla_pkg::led_state_t st;
  sla_pkg::rgb_t       colour;
  logic                st_valid;
  logic                st_take;
  logic                in_take;

  assign in_stall = st_valid && !st_take;
  assign in_take  = in_valid && !in_stall;

  sla_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  sla_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .conn_state (in_connection_state),
    .phase_step (regs.phase_step),
    .st_take    (st_take),
    .st_valid   (st_valid),
    .st         (st)
  );

  sla_wave u_wave (
    .clk        (clk),
    .rst_n      (rst_n),
    .st_valid   (st_valid),
    .st         (st),
    .flash_low  (regs.flash_low),
    .out_stall  (out_stall),
    .st_take    (st_take),
    .out_valid  (out_valid),
    .out_colour (colour),
    .out_level  (out_brightness)
  );

  assign out_red   = colour.red;
  assign out_green = colour.green;
  assign out_blue  = colour.blue;

endmodule
`default_nettype wire
